>>> design/bsdc_pkg.sv
// Shared types, register indexes and reset values for the bump sensor
// debounce classifier. No dependencies.
package bsdc_pkg;

  typedef enum logic [1:0] {
    REQ_POLL     = 2'd0,
    REQ_DETECT   = 2'd1,
    REQ_SET_DIR  = 2'd2,
    REQ_SET_POST = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_TRIG  = 2'd1,
    HIT_FRONT = 2'd2,
    HIT_REAR  = 2'd3
  } hit_code_t;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic [1:0] POST_NONE    = 2'd0;
  localparam logic [1:0] POST_FORWARD = 2'd1;
  localparam logic [1:0] POST_REVERSE = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEB_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FRONT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_REAR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SIDE    = 3'd4;

  localparam logic [7:0] RST_POLL_INTERVAL = 8'h10;
  localparam logic [3:0] RST_DEB_THRESHOLD = 4'h4;
  localparam logic [9:0] RST_SPEED_FRONT   = 10'h1D5;
  localparam logic [9:0] RST_SPEED_REAR    = 10'h2C0;
  localparam logic [9:0] RST_SPEED_SIDE    = 10'h0EA;

  typedef struct packed {
    logic [7:0] poll_interval;
    logic [3:0] debounce_threshold;
    logic [9:0] speed_front;
    logic [9:0] speed_rear;
    logic [9:0] speed_side;
  } cfg_t;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] tick;
    logic        sensor_level;
    logic [1:0]  motor_direction;
    logic        fwd;
  } item_t;

  typedef struct packed {
    hit_code_t   code;
    logic [9:0]  reverse_speed;
    logic        contact_flag;
    logic        debounced;
    logic [31:0] trigger_time;
    logic [1:0]  recovery_state;
    logic [31:0] recovery_time;
  } result_t;

endpackage

>>> design/bsdc_cfg.sv
// Configuration register file for the bump sensor debounce classifier.
// Depends on bsdc_pkg.
module bsdc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [bsdc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bsdc_pkg::CFG_DATA_W-1:0]  wr_data,
  output bsdc_pkg::cfg_t                   cfg
);
  import bsdc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_POLL_INTERVAL: cfg_nxt.poll_interval      = wr_data[7:0];
        CFG_DEB_THRESHOLD: cfg_nxt.debounce_threshold = wr_data[3:0];
        CFG_SPEED_FRONT:   cfg_nxt.speed_front        = wr_data;
        CFG_SPEED_REAR:    cfg_nxt.speed_rear         = wr_data;
        CFG_SPEED_SIDE:    cfg_nxt.speed_side         = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_interval      <= RST_POLL_INTERVAL;
      cfg_r.debounce_threshold <= RST_DEB_THRESHOLD;
      cfg_r.speed_front        <= RST_SPEED_FRONT;
      cfg_r.speed_rear         <= RST_SPEED_REAR;
      cfg_r.speed_side         <= RST_SPEED_SIDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/bsdc_engine.sv
// Debounce state and single-pass request evaluation: sampling, detection,
// classification and post-bump recording. Depends on bsdc_pkg.
module bsdc_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  bsdc_pkg::item_t   item,
  input  bsdc_pkg::cfg_t    cfg,
  output bsdc_pkg::result_t result
);
  import bsdc_pkg::*;

  logic [3:0]  high_count_r,      high_count_nxt;
  logic [31:0] last_sample_r,     last_sample_nxt;
  logic [1:0]  stored_dir_r,      stored_dir_nxt;
  logic        bump_active_r,     bump_active_nxt;
  logic [31:0] first_trig_r,      first_trig_nxt;
  logic        contact_seen_r,    contact_seen_nxt;
  logic [1:0]  post_dir_r,        post_dir_nxt;
  logic [31:0] post_tick_r,       post_tick_nxt;

  logic [31:0] tick_gap;
  logic        sample_ok;
  logic        deb_now;
  hit_code_t   code;

  assign tick_gap  = item.tick - last_sample_r;
  assign sample_ok = tick_gap > {24'd0, cfg.poll_interval};
  assign deb_now   = high_count_r >= cfg.debounce_threshold;

  always_comb begin
    high_count_nxt   = high_count_r;
    last_sample_nxt  = last_sample_r;
    stored_dir_nxt   = stored_dir_r;
    bump_active_nxt  = bump_active_r;
    first_trig_nxt   = first_trig_r;
    contact_seen_nxt = contact_seen_r;
    post_dir_nxt     = post_dir_r;
    post_tick_nxt    = post_tick_r;
    code             = HIT_NONE;
    case (item.req_type)
      REQ_POLL: begin
        if (sample_ok) begin
          last_sample_nxt = item.tick;
          if (!item.sensor_level) begin
            high_count_nxt = 4'd0;
          end else if (high_count_r < cfg.debounce_threshold) begin
            high_count_nxt = high_count_r + 4'd1;
          end
        end
      end
      REQ_DETECT: begin
        if (deb_now) begin
          contact_seen_nxt = 1'b1;
          code             = HIT_TRIG;
          if (!bump_active_r) begin
            first_trig_nxt  = last_sample_r;
            bump_active_nxt = 1'b1;
          end
        end else begin
          contact_seen_nxt = 1'b0;
          if (bump_active_r) begin
            bump_active_nxt = 1'b0;
            stored_dir_nxt  = DIR_NONE;
            if (stored_dir_r == DIR_LEFT) begin
              code = HIT_FRONT;
            end else if (stored_dir_r == DIR_RIGHT) begin
              code = HIT_REAR;
            end
          end
        end
      end
      REQ_SET_DIR: begin
        stored_dir_nxt = item.motor_direction;
      end
      REQ_SET_POST: begin
        post_dir_nxt  = item.fwd ? POST_FORWARD : POST_REVERSE;
        post_tick_nxt = last_sample_r;
      end
      default: begin
        code = HIT_NONE;
      end
    endcase
  end

  always_comb begin
    result.code = code;
    case (code)
      HIT_TRIG:  result.reverse_speed = cfg.speed_side;
      HIT_FRONT: result.reverse_speed = cfg.speed_front;
      HIT_REAR:  result.reverse_speed = cfg.speed_rear;
      default:   result.reverse_speed = 10'd0;
    endcase
    result.contact_flag   = contact_seen_nxt;
    result.debounced      = high_count_nxt >= cfg.debounce_threshold;
    result.trigger_time   = first_trig_nxt;
    result.recovery_state = post_dir_nxt;
    result.recovery_time  = post_tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_count_r   <= 4'd0;
      last_sample_r  <= 32'd0;
      stored_dir_r   <= DIR_NONE;
      bump_active_r  <= 1'b0;
      first_trig_r   <= 32'd0;
      contact_seen_r <= 1'b0;
      post_dir_r     <= POST_NONE;
      post_tick_r    <= 32'd0;
    end else if (advance) begin
      high_count_r   <= high_count_nxt;
      last_sample_r  <= last_sample_nxt;
      stored_dir_r   <= stored_dir_nxt;
      bump_active_r  <= bump_active_nxt;
      first_trig_r   <= first_trig_nxt;
      contact_seen_r <= contact_seen_nxt;
      post_dir_r     <= post_dir_nxt;
      post_tick_r    <= post_tick_nxt;
    end
  end

endmodule

>>> design/bump_sensor_debounce_classifier_core.sv
// Throughput: one request per cycle while the result is not held; the input
// register is evaluated in one pass against the state registers and written
// into the result register.
// Input stalls only while both registers are full and the result is held.
// Reset (synchronous, active low): state cleared, registers at defaults.
// Depends on bsdc_pkg, bsdc_cfg, bsdc_engine.
module bump_sensor_debounce_classifier_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_req_type,
  input  logic [31:0]                      in_sys_tick,
  input  logic                             in_sensor_level,
  input  logic [1:0]                       in_motor_direction,
  input  logic                             in_was_forward,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_bump_code,
  output logic [9:0]                       out_reverse_speed,
  output logic                             out_contact_flag,
  output logic                             out_debounced,
  output logic [31:0]                      out_trigger_time,
  output logic [1:0]                       out_recovery_state,
  output logic [31:0]                      out_recovery_time,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsdc_pkg::*;

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_valid_r, in_valid_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    in_take;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_take   = in_valid && in_ready;

  bsdc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bsdc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res_nxt)
  );

  always_comb begin
    item_nxt                 = item_r;
    item_nxt.req_type        = req_t'(in_req_type);
    item_nxt.tick            = in_sys_tick;
    item_nxt.sensor_level    = in_sensor_level;
    item_nxt.motor_direction = in_motor_direction;
    item_nxt.fwd             = in_was_forward;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bump_code      = res_r.code;
  assign out_reverse_speed  = res_r.reverse_speed;
  assign out_contact_flag   = res_r.contact_flag;
  assign out_debounced      = res_r.debounced;
  assign out_trigger_time   = res_r.trigger_time;
  assign out_recovery_state = res_r.recovery_state;
  assign out_recovery_time  = res_r.recovery_time;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_code_only_on_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.req_type != REQ_DETECT) |=> (res_r.code == HIT_NONE))
    else $error("bump code set by a non-detect request");

  a_speed_zero_on_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.code == HIT_NONE) |-> (res_r.reverse_speed == 10'd0))
    else $error("nonzero speed with no bump");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated request produced no result");
`endif

endmodule
